// ===== rtl/core/i2crm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package i2crm_pkg;

    localparam int unsigned MAX_READ_LENGTH_DEF = 16;
    localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd250;
    localparam int unsigned QUEUE_DEPTH = 2;

    // Transaction kinds.
    localparam logic [1:0] KIND_CMD_WRITE = 2'd0;
    localparam logic [1:0] KIND_REG_WRITE = 2'd1;
    localparam logic [1:0] KIND_BURST_READ = 2'd2;
    localparam logic [1:0] KIND_INVALID = 2'd3;

    // Opcodes.
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_START = 1'b1;

    // Byte stages within a transaction.
    localparam logic [2:0] STAGE_ADDR = 3'd0;
    localparam logic [2:0] STAGE_REG = 3'd1;
    localparam logic [2:0] STAGE_DATA = 3'd2;
    localparam logic [2:0] STAGE_RADDR = 3'd3;
    localparam logic [2:0] STAGE_READ = 3'd4;

    typedef enum logic [4:0] {
        PH_IDLE       = 5'd0,
        PH_ST1        = 5'd1,
        PH_ST2        = 5'd2,
        PH_TX_LOW     = 5'd3,
        PH_TX_HIGH    = 5'd4,
        PH_TX_TAIL    = 5'd5,
        PH_ACK_REL    = 5'd6,
        PH_ACK_HIGH   = 5'd7,
        PH_ACK_POLL   = 5'd8,
        PH_RX_LOW     = 5'd9,
        PH_RX_HIGH    = 5'd10,
        PH_RXACK_LOW  = 5'd11,
        PH_RXACK_HIGH = 5'd12,
        PH_STOP1      = 5'd13,
        PH_STOP2      = 5'd14,
        PH_ABORT2     = 5'd15
    } phase_t;

    // One classified tick request, as handed from front to sequencer.
    typedef struct packed {
        logic       start;
        logic [1:0] kind;
        logic [7:0] device;
        logic [7:0] regaddr;
        logic [7:0] data;
        logic [4:0] length;
        logic       sda;
    } tick_req_t;

endpackage

`default_nettype wire

// ===== rtl/core/i2c_register_master.sv =====
// Tick-driven I2C register master.
// Input channel (in_valid / in_stall): each request is one 4 us bus tick. With
// opcode set and the sequencer idle, it starts a command write, register write
// or burst read; otherwise it only advances the bus sequence by at most one phase.
// Output channel (out_valid / out_stall): exactly one result per request with
// the SCL/SDA levels after that tick, busy, a received byte when one completes,
// and done / ack_error when the stop finishes.
// Config channel (cfg_valid / cfg_ready): writes the acknowledge poll limit;
// always ready, to be written only while idle.
// Throughput is one request per cycle while the output is not stalled. A request
// passes through the two-entry request queue and then the sequencer, whose result
// register feeds the output.
// A stalled output holds its result; the queue absorbs up to two requests and
// then raises in_stall. Reset puts the sequencer idle, empties the queue and
// sets the poll limit to 250.
`timescale 1ns / 1ps
`default_nettype none

module i2c_register_master #(
    parameter int unsigned MAX_READ_LENGTH = i2crm_pkg::MAX_READ_LENGTH_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic       opcode,
    input  wire logic [1:0] kind,
    input  wire logic [7:0] device_address,
    input  wire logic [7:0] register_address,
    input  wire logic [7:0] write_data,
    input  wire logic [4:0] read_length,
    input  wire logic       sda_sample,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [7:0] cfg_data,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic            scl_level,
    output logic            sda_level,
    output logic            busy_res,
    output logic [7:0]      read_byte,
    output logic            read_valid,
    output logic            read_last,
    output logic            done_res,
    output logic            ack_error
);

    logic                 q_valid;
    logic                 q_pop;
    i2crm_pkg::tick_req_t q_head;

    i2crm_front #(
        .MAX_READ_LENGTH(MAX_READ_LENGTH)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .opcode          (opcode),
        .kind            (kind),
        .device_address  (device_address),
        .register_address(register_address),
        .write_data      (write_data),
        .read_length     (read_length),
        .sda_sample      (sda_sample),
        .q_valid         (q_valid),
        .q_head          (q_head),
        .q_pop           (q_pop)
    );

    i2crm_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .scl_level (scl_level),
        .sda_level (sda_level),
        .busy_res  (busy_res),
        .read_byte (read_byte),
        .read_valid(read_valid),
        .read_last (read_last),
        .done_res  (done_res),
        .ack_error (ack_error)
    );

endmodule

`default_nettype wire

// ===== rtl/core/i2crm_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module i2crm_front #(
    parameter int unsigned MAX_READ_LENGTH = i2crm_pkg::MAX_READ_LENGTH_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic                 opcode,
    input  wire logic [1:0]           kind,
    input  wire logic [7:0]           device_address,
    input  wire logic [7:0]           register_address,
    input  wire logic [7:0]           write_data,
    input  wire logic [4:0]           read_length,
    input  wire logic                 sda_sample,
    output logic                      q_valid,
    output i2crm_pkg::tick_req_t      q_head,
    input  wire logic                 q_pop
);

    i2crm_pkg::tick_req_t entry;
    i2crm_pkg::tick_req_t mem_reg [i2crm_pkg::QUEUE_DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    logic [4:0] len_sat;

    // Classify the request and clamp the burst length.
    always_comb
    begin
        if (read_length == 5'd0)
            len_sat = 5'd1;
        else if ({3'b000, read_length} > 8'(MAX_READ_LENGTH))
            len_sat = 5'(MAX_READ_LENGTH);
        else
            len_sat = read_length;
        entry.start   = (opcode == i2crm_pkg::OP_START) && (kind != i2crm_pkg::KIND_INVALID);
        entry.kind    = kind;
        entry.device  = device_address;
        entry.regaddr = register_address;
        entry.data    = write_data;
        entry.length  = len_sat;
        entry.sda     = sda_sample;
    end

    assign in_stall = (count_reg == 2'(i2crm_pkg::QUEUE_DEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != 2'd0);
    assign q_head   = mem_reg[rd_ptr_reg];

    // Queue pointer bookkeeping.
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= entry;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'(i2crm_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("pop from empty queue");
    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (len_sat != 5'd0))
        else $error("zero burst length queued");

endmodule

`default_nettype wire

// ===== rtl/core/i2crm_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none

module i2crm_seq (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 q_valid,
    input  wire i2crm_pkg::tick_req_t q_head,
    output logic                      q_pop,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [7:0]           cfg_data,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic                      scl_level,
    output logic                      sda_level,
    output logic                      busy_res,
    output logic [7:0]                read_byte,
    output logic                      read_valid,
    output logic                      read_last,
    output logic                      done_res,
    output logic                      ack_error
);

    i2crm_pkg::phase_t phase_reg, phase_next;
    logic [3:0] bit_reg, bit_next;
    logic [7:0] shift_reg, shift_next;
    logic [4:0] bytes_reg, bytes_next;
    logic [7:0] poll_reg, poll_next;
    logic [1:0] kind_reg, kind_next;
    logic [7:0] dev_reg, dev_next;
    logic [7:0] regaddr_reg, regaddr_next;
    logic [7:0] data_reg, data_next;
    logic [2:0] stage_reg, stage_next;
    logic [7:0] timeout_reg;
    logic       out_valid_reg;
    logic       step;
    logic       msb;
    logic [3:0] bit_inc;
    logic [7:0] shift_in;
    logic       last_byte;
    logic       timed_out;
    logic       o_scl, o_sda, o_rvalid, o_rlast, o_done, o_err;
    logic [7:0] o_rbyte;
    logic [4:0] bytes_dec;

    assign cfg_ready = 1'b1;
    assign step      = q_valid && (!out_valid_reg || !out_stall);
    assign q_pop     = step;
    assign out_valid = out_valid_reg;
    assign msb       = shift_reg[7];
    assign bit_inc   = bit_reg + 4'd1;
    assign shift_in  = {shift_reg[6:0], q_head.sda};
    assign last_byte = (bytes_reg <= 5'd1);
    assign timed_out = (poll_reg >= timeout_reg);
    assign bytes_dec = (bytes_reg != 5'd0) ? (bytes_reg - 5'd1) : bytes_reg;

    // Next-state and datapath update.
    always_comb
    begin
        phase_next   = phase_reg;
        bit_next     = bit_reg;
        shift_next   = shift_reg;
        bytes_next   = bytes_reg;
        poll_next    = poll_reg;
        kind_next    = kind_reg;
        dev_next     = dev_reg;
        regaddr_next = regaddr_reg;
        data_next    = data_reg;
        stage_next   = stage_reg;
        case (phase_reg)
            i2crm_pkg::PH_IDLE:
            begin
                if (q_head.start)
                begin
                    kind_next    = q_head.kind;
                    dev_next     = q_head.device;
                    regaddr_next = q_head.regaddr;
                    data_next    = q_head.data;
                    bytes_next   = q_head.length;
                    shift_next   = q_head.device;
                    bit_next     = 4'd0;
                    poll_next    = 8'd0;
                    stage_next   = i2crm_pkg::STAGE_ADDR;
                    phase_next   = i2crm_pkg::PH_ST2;
                end
            end
            i2crm_pkg::PH_ST1:
                phase_next = i2crm_pkg::PH_ST2;
            i2crm_pkg::PH_ST2:
            begin
                bit_next   = 4'd0;
                phase_next = i2crm_pkg::PH_TX_LOW;
            end
            i2crm_pkg::PH_TX_LOW:
                phase_next = i2crm_pkg::PH_TX_HIGH;
            i2crm_pkg::PH_TX_HIGH:
                phase_next = i2crm_pkg::PH_TX_TAIL;
            i2crm_pkg::PH_TX_TAIL:
            begin
                shift_next = {shift_reg[6:0], 1'b0};
                if (bit_inc >= 4'd8)
                begin
                    bit_next   = 4'd0;
                    phase_next = i2crm_pkg::PH_ACK_REL;
                end
                else
                begin
                    bit_next   = bit_inc;
                    phase_next = i2crm_pkg::PH_TX_LOW;
                end
            end
            i2crm_pkg::PH_ACK_REL:
            begin
                poll_next  = 8'd0;
                phase_next = i2crm_pkg::PH_ACK_HIGH;
            end
            i2crm_pkg::PH_ACK_HIGH:
                phase_next = i2crm_pkg::PH_ACK_POLL;
            i2crm_pkg::PH_ACK_POLL:
            begin
                if (!q_head.sda)
                begin
                    if (stage_reg == i2crm_pkg::STAGE_ADDR)
                    begin
                        stage_next = i2crm_pkg::STAGE_REG;
                        shift_next = regaddr_reg;
                        phase_next = i2crm_pkg::PH_TX_LOW;
                    end
                    else if (stage_reg == i2crm_pkg::STAGE_REG)
                    begin
                        if (kind_reg == i2crm_pkg::KIND_REG_WRITE)
                        begin
                            stage_next = i2crm_pkg::STAGE_DATA;
                            shift_next = data_reg;
                            phase_next = i2crm_pkg::PH_TX_LOW;
                        end
                        else if (kind_reg == i2crm_pkg::KIND_BURST_READ)
                        begin
                            stage_next = i2crm_pkg::STAGE_RADDR;
                            shift_next = dev_reg + 8'd1;
                            phase_next = i2crm_pkg::PH_ST1;
                        end
                        else
                            phase_next = i2crm_pkg::PH_STOP1;
                    end
                    else if (stage_reg == i2crm_pkg::STAGE_RADDR)
                    begin
                        stage_next = i2crm_pkg::STAGE_READ;
                        bit_next   = 4'd0;
                        shift_next = 8'd0;
                        phase_next = i2crm_pkg::PH_RX_LOW;
                    end
                    else
                        phase_next = i2crm_pkg::PH_STOP1;
                end
                else if (timed_out)
                    phase_next = i2crm_pkg::PH_ABORT2;
                else
                    poll_next = poll_reg + 8'd1;
            end
            i2crm_pkg::PH_RX_LOW:
                phase_next = i2crm_pkg::PH_RX_HIGH;
            i2crm_pkg::PH_RX_HIGH:
            begin
                shift_next = shift_in;
                if (bit_inc >= 4'd8)
                begin
                    bit_next   = 4'd0;
                    phase_next = i2crm_pkg::PH_RXACK_LOW;
                end
                else
                begin
                    bit_next   = bit_inc;
                    phase_next = i2crm_pkg::PH_RX_LOW;
                end
            end
            i2crm_pkg::PH_RXACK_LOW:
                phase_next = i2crm_pkg::PH_RXACK_HIGH;
            i2crm_pkg::PH_RXACK_HIGH:
            begin
                bytes_next = bytes_dec;
                if (bytes_dec == 5'd0)
                    phase_next = i2crm_pkg::PH_STOP1;
                else
                begin
                    shift_next = 8'd0;
                    phase_next = i2crm_pkg::PH_RX_LOW;
                end
            end
            i2crm_pkg::PH_STOP1:
                phase_next = i2crm_pkg::PH_STOP2;
            i2crm_pkg::PH_STOP2:
                phase_next = i2crm_pkg::PH_IDLE;
            i2crm_pkg::PH_ABORT2:
                phase_next = i2crm_pkg::PH_IDLE;
            default:
                phase_next = i2crm_pkg::PH_IDLE;
        endcase
    end

    // Line levels and status for the current tick.
    always_comb
    begin
        o_scl    = 1'b1;
        o_sda    = 1'b1;
        o_rbyte  = 8'd0;
        o_rvalid = 1'b0;
        o_rlast  = 1'b0;
        o_done   = 1'b0;
        o_err    = 1'b0;
        case (phase_reg)
            i2crm_pkg::PH_ST2:
                o_sda = 1'b0;
            i2crm_pkg::PH_TX_LOW, i2crm_pkg::PH_TX_TAIL:
            begin
                o_scl = 1'b0;
                o_sda = msb;
            end
            i2crm_pkg::PH_TX_HIGH:
                o_sda = msb;
            i2crm_pkg::PH_ACK_REL, i2crm_pkg::PH_RX_LOW:
                o_scl = 1'b0;
            i2crm_pkg::PH_ACK_POLL:
            begin
                if (!q_head.sda)
                    o_scl = 1'b0;
                else if (timed_out)
                begin
                    o_scl = 1'b0;
                    o_sda = 1'b0;
                end
            end
            i2crm_pkg::PH_RX_HIGH:
            begin
                if (bit_inc >= 4'd8)
                begin
                    o_rbyte  = shift_in;
                    o_rvalid = 1'b1;
                    o_rlast  = last_byte;
                end
            end
            i2crm_pkg::PH_RXACK_LOW:
            begin
                o_scl = 1'b0;
                o_sda = last_byte;
            end
            i2crm_pkg::PH_RXACK_HIGH:
                o_sda = last_byte;
            i2crm_pkg::PH_STOP1:
            begin
                o_scl = 1'b0;
                o_sda = 1'b0;
            end
            i2crm_pkg::PH_STOP2:
                o_done = 1'b1;
            i2crm_pkg::PH_ABORT2:
            begin
                o_done = 1'b1;
                o_err  = 1'b1;
            end
            default:
                o_scl = 1'b1;
        endcase
    end

    // Control state and timeout register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= i2crm_pkg::PH_IDLE;
            bit_reg       <= 4'd0;
            bytes_reg     <= 5'd0;
            poll_reg      <= 8'd0;
            kind_reg      <= 2'd0;
            stage_reg     <= i2crm_pkg::STAGE_ADDR;
            timeout_reg   <= i2crm_pkg::ACK_TIMEOUT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                timeout_reg <= cfg_data;
            if (step)
            begin
                phase_reg <= phase_next;
                bit_reg   <= bit_next;
                bytes_reg <= bytes_next;
                poll_reg  <= poll_next;
                kind_reg  <= kind_next;
                stage_reg <= stage_next;
            end
            if (step)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            shift_reg   <= shift_next;
            dev_reg     <= dev_next;
            regaddr_reg <= regaddr_next;
            data_reg    <= data_next;
            scl_level   <= o_scl;
            sda_level   <= o_sda;
            busy_res    <= (phase_next != i2crm_pkg::PH_IDLE);
            read_byte   <= o_rbyte;
            read_valid  <= o_rvalid;
            read_last   <= o_rlast;
            done_res    <= o_done;
            ack_error   <= o_err;
        end
    end

    a_err_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && ack_error) |-> done_res)
        else $error("ack error without completion");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && done_res) |-> !busy_res)
        else $error("completion while still busy");
    a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && read_last) |-> read_valid)
        else $error("last flag without read byte");
    // The abort phase is entered from the acknowledge poll and may be held by a stall.
    a_abort_path: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == i2crm_pkg::PH_ABORT2) |->
            (($past(phase_reg) == i2crm_pkg::PH_ACK_POLL) ||
             ($past(phase_reg) == i2crm_pkg::PH_ABORT2)))
        else $error("abort not entered from acknowledge poll");

endmodule

`default_nettype wire
